// ===== rtl/gif_frame_pixel_placer_unit_defines.svh =====
// Assertion macros for the pixel placer.
`ifndef GIF_FRAME_PIXEL_PLACER_UNIT_DEFINES_SVH
`define GIF_FRAME_PIXEL_PLACER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define GFPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GFPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GFPP_ASSERT(lbl, prop, msg)
`define GFPP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/gfpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfpp_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PIXEL = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_CANVAS_WIDTH  = 3'd0,
    REG_CANVAS_HEIGHT = 3'd1,
    REG_FRAME_LEFT    = 3'd2,
    REG_FRAME_TOP     = 3'd3,
    REG_FRAME_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT  = 3'd5,
    REG_INTERLACED    = 3'd6,
    REG_TRANSPARENT   = 3'd7
  } cfg_reg_t;

  localparam logic [3:0]  STEP_PASS0 = 4'd8;
  localparam logic [3:0]  STEP_PASS1 = 4'd8;
  localparam logic [3:0]  STEP_PASS2 = 4'd4;
  localparam logic [3:0]  STEP_PASS3 = 4'd2;
  localparam logic [15:0] ROW_PASS1  = 16'd4;
  localparam logic [15:0] ROW_PASS2  = 16'd2;
  localparam logic [15:0] ROW_PASS3  = 16'd1;
  localparam logic [2:0]  PASS_FIRST = 3'd0;
  localparam logic [2:0]  PASS_1     = 3'd1;
  localparam logic [2:0]  PASS_2     = 3'd2;
  localparam logic [2:0]  PASS_3     = 3'd3;
  localparam logic [2:0]  PASS_DONE  = 3'd4;
  localparam logic [8:0]  TRANSP_NONE = 9'h1FF;

  typedef struct packed {
    logic        clear;
    logic        load;
    logic        read;
    logic [7:0]  idx;
    logic [23:0] rgb;
  } pal_req_t;

endpackage

`default_nettype wire

// ===== rtl/gfpp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gfpp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] color_index;
  logic [7:0] load_red;
  logic [7:0] load_green;
  logic [7:0] load_blue;
  modport source (output valid, opcode, color_index, load_red, load_green, load_blue,
                  input ready);
  modport sink   (input valid, opcode, color_index, load_red, load_green, load_blue,
                  output ready);
endinterface

interface gfpp_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [15:0] canvas_x;
  logic [15:0] canvas_y;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        frame_done;
  modport source (output valid, write_enable, canvas_x, canvas_y, out_red, out_green,
                  out_blue, frame_done, input ready);
  modport sink   (input valid, write_enable, canvas_x, canvas_y, out_red, out_green,
                  out_blue, frame_done, output ready);
endinterface

interface gfpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gfpp_palette.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfpp_palette import gfpp_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pal_req_t    req,
  output logic        vld,
  output logic [23:0] rgb
);

  localparam int AW = $clog2(DEPTH);

  logic [23:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [AW-1:0]    addr;

  assign addr = req.idx[AW-1:0];
  assign vld  = vld_r[addr];

  always_ff @(posedge clk) begin
    if (req.load) begin
      mem[addr] <= req.rgb;
    end
    if (req.read) begin
      rgb <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      vld_r <= '0;
    end else if (req.load) begin
      vld_r[addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gif_frame_pixel_placer_unit.sv =====
// channel   role    accept when          payload
// cfg_if    sink    valid && ready       index, data (ready tied high)
// in_if     sink    valid && ready       opcode, color_index, load_red/green/blue
// out_if    source  valid && ready       write_enable, canvas_x/y, out_rgb, frame_done
//
// One item per cycle unless stalled; a pixel result follows in the next cycle.
// Palette color lives in a single-port-write RAM with registered read; the
// read is issued on the pixel's accept edge, so loads never race reads.
// in_if.ready drops only while a result sits in the output register unaccepted.
// Synchronous reset sets config, position, s1_valid_r; clears all palette valid marks.
`timescale 1ns / 1ps
`default_nettype none
`include "gif_frame_pixel_placer_unit_defines.svh"

module gif_frame_pixel_placer_unit import gfpp_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  gfpp_cfg_if.sink   cfg_if,
  gfpp_in_if.sink    in_if,
  gfpp_out_if.source out_if
);

  logic [15:0] canvas_w_r, canvas_h_r, frame_left_r, frame_top_r, frame_w_r, frame_h_r;
  logic        interlaced_r;
  logic [8:0]  transp_r;

  logic [15:0] col_r, row_r, col_nxt, row_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [2:0]  pass_r, pass_nxt;
  logic        done_r, done_nxt;

  logic        s1_valid_r, s1_we_r, s1_done_r;
  logic [15:0] s1_x_r, s1_y_r;

  op_t         op;
  logic        in_acc, is_start, is_load, is_pixel;
  logic        in_range, transp_hit, on_canvas, we;
  logic [16:0] x_sum, y_sum, col_inc, row_inc, row_cand;
  logic [15:0] w_eff, h_eff;
  pal_req_t    pal_req;
  logic        pal_vld;
  logic [23:0] pal_rgb;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r   <= 16'd1;
      canvas_h_r   <= 16'd1;
      frame_left_r <= 16'd0;
      frame_top_r  <= 16'd0;
      frame_w_r    <= 16'd1;
      frame_h_r    <= 16'd1;
      interlaced_r <= 1'b0;
      transp_r     <= TRANSP_NONE;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_CANVAS_WIDTH:  canvas_w_r   <= cfg_if.data;
        REG_CANVAS_HEIGHT: canvas_h_r   <= cfg_if.data;
        REG_FRAME_LEFT:    frame_left_r <= cfg_if.data;
        REG_FRAME_TOP:     frame_top_r  <= cfg_if.data;
        REG_FRAME_WIDTH:   frame_w_r    <= cfg_if.data;
        REG_FRAME_HEIGHT:  frame_h_r    <= cfg_if.data;
        REG_INTERLACED:    interlaced_r <= cfg_if.data[0];
        REG_TRANSPARENT:   transp_r     <= cfg_if.data[8:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !s1_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;
  assign op          = op_t'(in_if.opcode);
  assign is_start    = in_acc && (op == OP_START);
  assign is_load     = in_acc && (op == OP_LOAD);
  assign is_pixel    = in_acc && (op == OP_PIXEL);

  assign in_range = {1'b0, in_if.color_index} < 9'(PALETTE_DEPTH);

  assign pal_req.clear = is_start;
  assign pal_req.load  = is_load && in_range;
  assign pal_req.read  = is_pixel;
  assign pal_req.idx   = in_if.color_index;
  assign pal_req.rgb   = {in_if.load_red, in_if.load_green, in_if.load_blue};

  gfpp_palette #(.DEPTH(PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pal_req),
    .vld   (pal_vld),
    .rgb   (pal_rgb)
  );

  assign x_sum      = {1'b0, frame_left_r} + {1'b0, col_r};
  assign y_sum      = {1'b0, frame_top_r} + {1'b0, row_r};
  assign on_canvas  = (x_sum < {1'b0, canvas_w_r}) && (y_sum < {1'b0, canvas_h_r});
  assign transp_hit = !transp_r[8] && (transp_r[7:0] == in_if.color_index);
  assign we         = in_range && pal_vld && !transp_hit && on_canvas;

  // position advance, interlace pass skip resolved in one step
  assign w_eff    = (frame_w_r == 16'd0) ? 16'd1 : frame_w_r;
  assign h_eff    = (frame_h_r == 16'd0) ? 16'd1 : frame_h_r;
  assign col_inc  = {1'b0, col_r} + 17'd1;
  assign row_inc  = {1'b0, row_r} + 17'd1;
  assign row_cand = {1'b0, row_r} + 17'(step_r);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    step_nxt = step_r;
    pass_nxt = pass_r;
    done_nxt = done_r;
    if (col_inc < {1'b0, w_eff}) begin
      col_nxt = col_inc[15:0];
    end else begin
      col_nxt = 16'd0;
      if (!interlaced_r) begin
        if (row_inc >= {1'b0, h_eff}) begin
          done_nxt = 1'b1;
        end else begin
          row_nxt = row_inc[15:0];
        end
      end else begin
        priority if (row_cand < {1'b0, h_eff}) begin
          row_nxt = row_cand[15:0];
        end else if (pass_r == PASS_FIRST && h_eff > ROW_PASS1) begin
          row_nxt  = ROW_PASS1;
          step_nxt = STEP_PASS1;
          pass_nxt = PASS_1;
        end else if (pass_r <= PASS_1 && h_eff > ROW_PASS2) begin
          row_nxt  = ROW_PASS2;
          step_nxt = STEP_PASS2;
          pass_nxt = PASS_2;
        end else if (pass_r <= PASS_2 && h_eff > ROW_PASS3) begin
          row_nxt  = ROW_PASS3;
          step_nxt = STEP_PASS3;
          pass_nxt = PASS_3;
        end else begin
          pass_nxt = PASS_DONE;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || is_start) begin
      col_r  <= 16'd0;
      row_r  <= 16'd0;
      step_r <= STEP_PASS0;
      pass_r <= PASS_FIRST;
      done_r <= 1'b0;
    end else if (is_pixel && !done_r) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      step_r <= step_nxt;
      pass_r <= pass_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (is_pixel) begin
      s1_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_pixel) begin
      s1_we_r   <= !done_r && we;
      s1_x_r    <= (!done_r && we) ? x_sum[15:0] : 16'd0;
      s1_y_r    <= (!done_r && we) ? y_sum[15:0] : 16'd0;
      s1_done_r <= done_r || done_nxt;
    end
  end

  assign out_if.valid        = s1_valid_r;
  assign out_if.write_enable = s1_we_r;
  assign out_if.canvas_x     = s1_x_r;
  assign out_if.canvas_y     = s1_y_r;
  assign out_if.out_red      = s1_we_r ? pal_rgb[23:16] : 8'd0;
  assign out_if.out_green    = s1_we_r ? pal_rgb[15:8]  : 8'd0;
  assign out_if.out_blue     = s1_we_r ? pal_rgb[7:0]   : 8'd0;
  assign out_if.frame_done   = s1_done_r;

  `GFPP_ASSERT(a_pass_done, (pass_r == PASS_DONE) |-> done_r, "final pass without done")
  `GFPP_ASSERT(a_start_clears, is_start |=> (!done_r && pass_r == PASS_FIRST && col_r == 16'd0 && row_r == 16'd0), "start item did not clear position")
  `GFPP_ASSERT(a_after_done, (is_pixel && done_r) |=> (out_if.valid && out_if.frame_done && !out_if.write_enable), "pixel after frame end wrote")
  `GFPP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_if.valid, "result valid after reset")

endmodule

`default_nettype wire

// ===== tb/gfpp_placer_checker.sv =====
`timescale 1ns / 1ps

module gfpp_placer_checker import gfpp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gfpp_cfg_if  cfg_w,
  gfpp_in_if   in_w,
  gfpp_out_if  out_w,
  output int   err_count,
  output int   pending
);

  typedef struct packed {
    logic        we;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        done;
  } placement_t;

  placement_t placements_due[$];

  logic [15:0] cv_w, cv_h, fr_left, fr_top, fr_w, fr_h;
  logic        ilace;
  logic [8:0]  transp;

  logic [23:0] pal_rgb[256];
  bit          pal_ok[256];
  logic [15:0] col, row;
  logic [3:0]  row_inc;
  logic [2:0]  pass_no;
  logic        frame_over;

  function automatic void step_position();
    int unsigned w, h, r;
    w = (fr_w == 16'd0) ? 32'd1 : 32'(fr_w);
    h = (fr_h == 16'd0) ? 32'd1 : 32'(fr_h);
    if (32'(col) + 32'd1 < w) begin
      col = col + 16'd1;
      return;
    end
    col = '0;
    if (!ilace) begin
      r = 32'(row) + 32'd1;
      if (r >= h) frame_over = 1'b1;
      else row = r[15:0];
      return;
    end
    r = 32'(row) + 32'(row_inc);
    while (r >= h) begin
      pass_no = pass_no + 3'd1;
      case (pass_no)
        PASS_1: begin
          r = 32'(ROW_PASS1);
          row_inc = STEP_PASS1;
        end
        PASS_2: begin
          r = 32'(ROW_PASS2);
          row_inc = STEP_PASS2;
        end
        PASS_3: begin
          r = 32'(ROW_PASS3);
          row_inc = STEP_PASS3;
        end
        default: begin
          pass_no = PASS_DONE;
          frame_over = 1'b1;
          return;
        end
      endcase
    end
    row = r[15:0];
  endfunction

  function automatic placement_t place_pixel(input logic [7:0] idx);
    placement_t res;
    int unsigned px, py;
    bit hit;
    res = '0;
    if (frame_over) begin
      res.done = 1'b1;
      return res;
    end
    px = 32'(fr_left) + 32'(col);
    py = 32'(fr_top) + 32'(row);
    hit = pal_ok[idx];
    if (!transp[8] && transp[7:0] == idx) hit = 1'b0;
    if (px >= 32'(cv_w) || py >= 32'(cv_h)) hit = 1'b0;
    if (hit) begin
      res.we = 1'b1;
      res.x = px[15:0];
      res.y = py[15:0];
      {res.r, res.g, res.b} = pal_rgb[idx];
    end
    step_position();
    res.done = frame_over;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    placement_t want;
    if (!rst_n) begin
      cv_w = 16'd1;
      cv_h = 16'd1;
      fr_left = '0;
      fr_top = '0;
      fr_w = 16'd1;
      fr_h = 16'd1;
      ilace = 1'b0;
      transp = TRANSP_NONE;
      pal_ok = '{default: 1'b0};
      col = '0;
      row = '0;
      row_inc = STEP_PASS0;
      pass_no = PASS_FIRST;
      frame_over = 1'b0;
      placements_due.delete();
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          REG_CANVAS_WIDTH:  cv_w = cfg_w.data;
          REG_CANVAS_HEIGHT: cv_h = cfg_w.data;
          REG_FRAME_LEFT:    fr_left = cfg_w.data;
          REG_FRAME_TOP:     fr_top = cfg_w.data;
          REG_FRAME_WIDTH:   fr_w = cfg_w.data;
          REG_FRAME_HEIGHT:  fr_h = cfg_w.data;
          REG_INTERLACED:    ilace = cfg_w.data[0];
          REG_TRANSPARENT:   transp = cfg_w.data[8:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        case (in_w.opcode)
          OP_START: begin
            col = '0;
            row = '0;
            row_inc = STEP_PASS0;
            pass_no = PASS_FIRST;
            frame_over = 1'b0;
            pal_ok = '{default: 1'b0};
          end
          OP_LOAD: begin
            pal_rgb[in_w.color_index] = {in_w.load_red, in_w.load_green, in_w.load_blue};
            pal_ok[in_w.color_index] = 1'b1;
          end
          OP_PIXEL: placements_due.insert(placements_due.size(),
                                          place_pixel(in_w.color_index));
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        if (placements_due.size() == 0) begin
          $error("result item with no expectation pending");
          err_count++;
        end else begin
          want = placements_due.pop_front();
          check_field("write_enable", 32'(want.we), 32'(out_w.write_enable));
          check_field("canvas_x", 32'(want.x), 32'(out_w.canvas_x));
          check_field("canvas_y", 32'(want.y), 32'(out_w.canvas_y));
          check_field("out_red", 32'(want.r), 32'(out_w.out_red));
          check_field("out_green", 32'(want.g), 32'(out_w.out_green));
          check_field("out_blue", 32'(want.b), 32'(out_w.out_blue));
          check_field("frame_done", 32'(want.done), 32'(out_w.frame_done));
        end
      end
    end
    pending = placements_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import gfpp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;

  gfpp_cfg_if cfg_bus ();
  gfpp_in_if  in_bus ();
  gfpp_out_if out_bus ();

  int err_count;
  int pending;
  bit src_idle_on;
  bit snk_idle_on;
  bit stall_req;
  bit loaded[256];
  logic [7:0] frame_pal[$];
  logic [15:0] cur_fw, cur_fh;
  int sent;

  gif_frame_pixel_placer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_bus),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  gfpp_placer_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_w     (cfg_bus),
    .in_w      (in_bus),
    .out_w     (out_bus),
    .err_count (err_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin : sink_drive
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_bus.ready <= !(snk_idle_on && $urandom_range(99) < 34);
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // returns at the accepting rising edge; valid is left for the next caller
  task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
                           input logic [23:0] rgb);
    @(negedge clk);
    while (src_idle_on && $urandom_range(99) < 34) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.opcode <= op;
    in_bus.color_index <= idx;
    {in_bus.load_red, in_bus.load_green, in_bus.load_blue} <= rgb;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (op != OP_UNUSED) sent++;
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [23:0] rgb);
    send_item(OP_LOAD, idx, rgb);
    loaded[idx] = 1'b1;
    frame_pal.insert(frame_pal.size(), idx);
  endtask

  // never read a palette slot that has not been written at least once
  task automatic place(input logic [7:0] idx);
    if (!loaded[idx]) load_entry(idx, 24'($urandom));
    send_item(OP_PIXEL, idx, 24'($urandom));
  endtask

  task automatic new_frame();
    send_item(OP_START, 8'($urandom), 24'($urandom));
    frame_pal.delete();
  endtask

  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= r;
    cfg_bus.data <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] cw, ch, fl, ft, fw, fh,
                          input bit il, input logic [8:0] tr);
    logic [15:0] junk;
    junk = 16'($urandom);
    settle();
    write_reg(REG_CANVAS_WIDTH, cw);
    write_reg(REG_CANVAS_HEIGHT, ch);
    write_reg(REG_FRAME_LEFT, fl);
    write_reg(REG_FRAME_TOP, ft);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_INTERLACED, {junk[15:1], il});
    write_reg(REG_TRANSPARENT, {junk[15:9], tr});
    cur_fw = fw;
    cur_fh = fh;
  endtask

  function automatic logic [15:0] pick_dim(input int hi);
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return 16'hFFFF;
    if (roll < 12) return 16'($urandom);
    return 16'($urandom_range(hi, 0));
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(1, 0)) return 8'($urandom_range(15, 0));
    return 8'($urandom);
  endfunction

  task automatic random_regs();
    logic [8:0] tr;
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) tr = TRANSP_NONE;
    else if (roll < 35) tr = {1'b1, 8'($urandom)};
    else if (roll < 80) tr = 9'($urandom_range(15, 0));
    else tr = {1'b0, 8'($urandom)};
    set_regs(pick_dim(16), pick_dim(16), pick_dim(8), pick_dim(8), pick_dim(6),
             pick_dim(20), 1'($urandom_range(1, 0)), tr);
  endtask

  initial begin : stimulus
    int frame_no, n, roll;
    longint area;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = OP_START;
    in_bus.color_index = '0;
    in_bus.load_red = '0;
    in_bus.load_green = '0;
    in_bus.load_blue = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_CANVAS_WIDTH;
    cfg_bus.data = '0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    stall_req = 1'b0;
    cur_fw = 16'd1;
    cur_fh = 16'd1;
    sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: 1x1 frame on a 1x1 canvas
    place(8'd0);
    place(8'd0);
    new_frame();
    place(8'd0);

    set_regs(16'd4, 16'd4, 16'd2, 16'd1, 16'd3, 16'd2, 1'b0, 9'd5);
    new_frame();
    load_entry(8'd5, 24'h123456);
    load_entry(8'd255, 24'hFFFFFF);
    load_entry(8'd7, 24'h000000);
    place(8'd5);
    place(8'd255);
    place(8'd7);
    place(8'd255);
    place(8'd255);
    place(8'd7);
    place(8'd7);
    send_item(OP_UNUSED, 8'hFF, 24'hFFFFFF);

    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 9'h100);
    new_frame();
    load_entry(8'd1, 24'hA5A5A5);
    place(8'd1);
    place(8'd1);

    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'd3, 16'hFFFF, 1'b1, TRANSP_NONE);
    new_frame();
    load_entry(8'd0, 24'h5A5A5A);
    place(8'd0);
    place(8'd0);
    place(8'd0);

    frame_no = 0;
    while (sent < 650) begin
      frame_no++;
      src_idle_on = (frame_no < 8 || frame_no > 12);
      snk_idle_on = src_idle_on;
      if (frame_no == 1 || $urandom_range(99) < 70) random_regs();
      if ($urandom_range(99) < 85) new_frame();
      repeat ($urandom_range(6, 1)) load_entry(pick_index(), 24'($urandom));
      area = longint'(cur_fw == 0 ? 1 : cur_fw) * longint'(cur_fh == 0 ? 1 : cur_fh);
      n = (area > 48) ? int'($urandom_range(48, 12))
                      : int'(area) + int'($urandom_range(3, 0));
      if (frame_no == 4) begin
        src_idle_on = 1'b0;
        stall_req = 1'b1;
        n = 40;
      end
      for (int i = 0; i < n; i++) begin
        roll = $urandom_range(99);
        if (roll < 3) send_item(OP_UNUSED, 8'($urandom), 24'($urandom));
        else if (roll < 7) load_entry(pick_index(), 24'($urandom));
        else if (roll < 8) new_frame();
        if (frame_pal.size() > 0 && $urandom_range(99) < 75)
          place(frame_pal[$urandom_range(frame_pal.size() - 1)]);
        else
          place(8'($urandom));
      end
    end

    settle();
    repeat (6) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
